>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define CSC_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define CSC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/csc_pkg.sv
`default_nettype none

package csc_pkg;

  localparam int U_FRAC     = 24;
  localparam int SQRT_STEPS = 31;
  localparam int NDIV_STEPS = 16;
  localparam logic [15:0] ONE_Q14 = 16'd16384;

  typedef struct packed {
    logic signed [24:0] apx;
    logic signed [24:0] apy;
    logic signed [24:0] abx;
    logic signed [24:0] aby;
    logic [22:0]        radius;
    logic               ex;
  } front_t;

  typedef struct packed {
    front_t             f;
    logic signed [49:0] pdx;
    logic signed [49:0] pdy;
    logic [48:0]        lxx;
    logic [48:0]        lyy;
  } prod_t;

  typedef struct packed {
    front_t             f;
    logic signed [50:0] dot;
    logic [49:0]        len2;
  } sum_t;

  typedef struct packed {
    front_t      f;
    logic        rej;
    logic [49:0] rem;
    logic [49:0] len2;
    logic [24:0] u;
  } udiv_t;

  typedef struct packed {
    front_t             f;
    logic               rej;
    logic signed [50:0] ox;
    logic signed [50:0] oy;
  } ofs_t;

  typedef struct packed {
    logic [22:0]        radius;
    logic               ex;
    logic               rej;
    logic signed [27:0] dx;
    logic signed [27:0] dy;
  } dxy_t;

  typedef struct packed {
    dxy_t        d;
    logic [55:0] sx;
    logic [55:0] sy;
    logic [45:0] r2;
  } sq_t;

  typedef struct packed {
    dxy_t        d;
    logic [56:0] dist2;
    logic [45:0] r2;
  } d2_t;

  typedef struct packed {
    logic [22:0]        radius;
    logic               ex;
    logic               hit;
    logic               nz;
    logic signed [27:0] dx;
    logic signed [27:0] dy;
    logic [61:0]        x;
    logic [61:0]        res;
  } sqrt_t;

  typedef struct packed {
    logic [22:0] radius;
    logic        ex;
    logic        hit;
    logic        nz;
    logic        sgnx;
    logic        sgny;
    logic [30:0] root;
    logic [45:0] numx;
    logic [45:0] numy;
  } num_t;

  typedef struct packed {
    logic [22:0] radius;
    logic        ex;
    logic        hit;
    logic        nz;
    logic        sgnx;
    logic        sgny;
    logic        ovfx;
    logic        ovfy;
    logic [30:0] root;
    logic [46:0] remx;
    logic [46:0] remy;
    logic [15:0] qx;
    logic [15:0] qy;
  } ndiv_t;

  typedef struct packed {
    logic               ex;
    logic               hit;
    logic               nz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [31:0] pen;
  } fin_t;

  typedef struct packed {
    logic               ex;
    logic               hit;
    logic               nz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [47:0] ppx;
    logic signed [47:0] ppy;
  } pp_t;

endpackage

`default_nettype wire

>>> sv/circle_segment_collision_unit.sv
// Throughput: one beat per cycle; the whole pipeline holds while the
// output register is full and not taken.
// Depth is set by the 24-step projection divider, the 31-step square root
// and the 16-step normal divider, one step per stage.
// Reset: synchronous, active low; clears all stage valid bits.
`default_nettype none
`include "assert_macros.svh"

module circle_segment_collision_unit
  import csc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // center_x, center_y, radius, seg_start_x, seg_start_y, seg_end_x, seg_end_y, pad
  input  wire logic [167:0] in_tdata,
  // is_exit
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // normal_x, normal_y, push_x, push_y
  output logic [79:0]       out_tdata,
  // hit
  output logic              out_tuser
);

  logic en;

  // front stages
  logic   s1_v_r, s2_v_r, s3_v_r;
  front_t s1_r, s1_nxt;
  prod_t  s2_r, s2_nxt;
  sum_t   s3_r;

  // projection divider
  logic  ud_v_r [0:U_FRAC];
  udiv_t ud_r   [0:U_FRAC];
  udiv_t ud0_nxt;

  logic ofs_v_r, dxy_v_r, sq_v_r, d2_v_r;
  ofs_t ofs_r, ofs_nxt;
  dxy_t dxy_r, dxy_nxt;
  sq_t  sq_r, sq_nxt;
  d2_t  d2_r;

  // square root
  logic  sq_vld_r [0:SQRT_STEPS];
  sqrt_t sqr_r    [0:SQRT_STEPS];
  sqrt_t sqr0_nxt;

  // normal divider
  logic  num_v_r;
  num_t  num_r, num_nxt;
  logic  nd_v_r [0:NDIV_STEPS];
  ndiv_t nd_r   [0:NDIV_STEPS];
  ndiv_t nd0_nxt;

  logic fin_v_r, pp_v_r;
  fin_t fin_r, fin_nxt;
  pp_t  pp_r, pp_nxt;

  logic        out_v_r, out_hit_r, out_ex_r;
  logic [15:0] out_nx_r, out_ny_r;
  logic [23:0] out_px_r, out_py_r;
  logic [15:0] out_nx_nxt, out_ny_nxt;
  logic [23:0] out_px_nxt, out_py_nxt;

  assign en        = !out_v_r || out_tready;
  assign in_tready = en;

  // stage 1: differences
  always_comb begin
    s1_nxt.apx    = 25'($signed(in_tdata[23:0]))   - 25'($signed(in_tdata[94:71]));
    s1_nxt.apy    = 25'($signed(in_tdata[47:24]))  - 25'($signed(in_tdata[118:95]));
    s1_nxt.abx    = 25'($signed(in_tdata[142:119])) - 25'($signed(in_tdata[94:71]));
    s1_nxt.aby    = 25'($signed(in_tdata[166:143])) - 25'($signed(in_tdata[118:95]));
    s1_nxt.radius = in_tdata[70:48];
    s1_nxt.ex     = in_tuser;
  end

  // stage 2: products
  always_comb begin
    s2_nxt.f   = s1_r;
    s2_nxt.pdx = $signed(s1_r.apx) * $signed(s1_r.abx);
    s2_nxt.pdy = $signed(s1_r.apy) * $signed(s1_r.aby);
    s2_nxt.lxx = 49'($signed(s1_r.abx) * $signed(s1_r.abx));
    s2_nxt.lyy = 49'($signed(s1_r.aby) * $signed(s1_r.aby));
  end

  // stage 4: reject test and divider seed
  always_comb begin
    ud0_nxt.f    = s3_r.f;
    ud0_nxt.len2 = s3_r.len2;
    ud0_nxt.rej  = (s3_r.len2 == '0) || s3_r.dot[50] ||
                   (s3_r.dot[49:0] > s3_r.len2);
    if (s3_r.dot[49:0] == s3_r.len2) begin
      ud0_nxt.u   = 25'd1;
      ud0_nxt.rem = '0;
    end else begin
      ud0_nxt.u   = '0;
      ud0_nxt.rem = s3_r.dot[49:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      ud_v_r[0] <= 1'b0;
    end else if (en) begin
      s1_v_r    <= in_tvalid;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      ud_v_r[0] <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r      <= s1_nxt;
      s2_r      <= s2_nxt;
      s3_r.f    <= s2_r.f;
      s3_r.dot  <= 51'(s2_r.pdx) + 51'(s2_r.pdy);
      s3_r.len2 <= 50'(s2_r.lxx) + 50'(s2_r.lyy);
      ud_r[0]   <= ud0_nxt;
    end
  end

  // projection divider: one quotient bit per stage
  for (genvar k = 0; k < U_FRAC; k++) begin : g_udiv
    logic [50:0] rem_sh;
    logic        ge;
    udiv_t       nxt;
    always_comb begin
      rem_sh   = {ud_r[k].rem, 1'b0};
      ge       = rem_sh >= {1'b0, ud_r[k].len2};
      nxt      = ud_r[k];
      nxt.rem  = ge ? 50'(rem_sh - {1'b0, ud_r[k].len2}) : rem_sh[49:0];
      nxt.u    = {ud_r[k].u[23:0], ge};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ud_v_r[k+1] <= 1'b0;
      end else if (en) begin
        ud_v_r[k+1] <= ud_v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ud_r[k+1] <= nxt;
      end
    end
  end

  // offset products, rounding, squares
  logic [50:0] magx, magy;
  logic [26:0] tx, ty;
  logic signed [27:0] offx, offy;

  always_comb begin
    ofs_nxt.f   = ud_r[U_FRAC].f;
    ofs_nxt.rej = ud_r[U_FRAC].rej;
    ofs_nxt.ox  = $signed({1'b0, ud_r[U_FRAC].u}) * $signed(ud_r[U_FRAC].f.abx);
    ofs_nxt.oy  = $signed({1'b0, ud_r[U_FRAC].u}) * $signed(ud_r[U_FRAC].f.aby);

    magx = ofs_r.ox[50] ? 51'(-ofs_r.ox) : 51'(ofs_r.ox);
    magy = ofs_r.oy[50] ? 51'(-ofs_r.oy) : 51'(ofs_r.oy);
    tx   = 27'((magx + 51'(1 << (U_FRAC - 1))) >> U_FRAC);
    ty   = 27'((magy + 51'(1 << (U_FRAC - 1))) >> U_FRAC);
    offx = ofs_r.ox[50] ? -$signed({1'b0, tx}) : $signed({1'b0, tx});
    offy = ofs_r.oy[50] ? -$signed({1'b0, ty}) : $signed({1'b0, ty});
    dxy_nxt.radius = ofs_r.f.radius;
    dxy_nxt.ex     = ofs_r.f.ex;
    dxy_nxt.rej    = ofs_r.rej;
    dxy_nxt.dx     = 28'($signed(ofs_r.f.apx)) - offx;
    dxy_nxt.dy     = 28'($signed(ofs_r.f.apy)) - offy;

    sq_nxt.d  = dxy_r;
    sq_nxt.sx = 56'($signed(dxy_r.dx) * $signed(dxy_r.dx));
    sq_nxt.sy = 56'($signed(dxy_r.dy) * $signed(dxy_r.dy));
    sq_nxt.r2 = dxy_r.radius * dxy_r.radius;
  end

  // hit test and square root seed
  always_comb begin
    sqr0_nxt.radius = d2_r.d.radius;
    sqr0_nxt.ex     = d2_r.d.ex;
    sqr0_nxt.hit    = !d2_r.d.rej && (d2_r.dist2 < {11'b0, d2_r.r2});
    sqr0_nxt.nz     = d2_r.dist2 != '0;
    sqr0_nxt.dx     = d2_r.d.dx;
    sqr0_nxt.dy     = d2_r.d.dy;
    sqr0_nxt.x      = {d2_r.dist2[45:0], 16'b0};
    sqr0_nxt.res    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_v_r     <= 1'b0;
      dxy_v_r     <= 1'b0;
      sq_v_r      <= 1'b0;
      d2_v_r      <= 1'b0;
      sq_vld_r[0] <= 1'b0;
    end else if (en) begin
      ofs_v_r     <= ud_v_r[U_FRAC];
      dxy_v_r     <= ofs_v_r;
      sq_v_r      <= dxy_v_r;
      d2_v_r      <= sq_v_r;
      sq_vld_r[0] <= d2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ofs_r      <= ofs_nxt;
      dxy_r      <= dxy_nxt;
      sq_r       <= sq_nxt;
      d2_r.d     <= sq_r.d;
      d2_r.r2    <= sq_r.r2;
      d2_r.dist2 <= 57'(sq_r.sx) + 57'(sq_r.sy);
      sqr_r[0]   <= sqr0_nxt;
    end
  end

  // square root: one result bit per stage
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'(1) << (2 * (SQRT_STEPS - 1 - i));
    logic [61:0] trial;
    sqrt_t       nxt;
    always_comb begin
      trial = sqr_r[i].res + BIT;
      nxt   = sqr_r[i];
      if (sqr_r[i].x >= trial) begin
        nxt.x   = sqr_r[i].x - trial;
        nxt.res = (sqr_r[i].res >> 1) + BIT;
      end else begin
        nxt.res = sqr_r[i].res >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[i+1] <= 1'b0;
      end else if (en) begin
        sq_vld_r[i+1] <= sq_vld_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sqr_r[i+1] <= nxt;
      end
    end
  end

  // normal numerators and divider seed
  logic [27:0] adx, ady;
  always_comb begin
    adx = sqr_r[SQRT_STEPS].dx[27] ? 28'(-sqr_r[SQRT_STEPS].dx) : sqr_r[SQRT_STEPS].dx;
    ady = sqr_r[SQRT_STEPS].dy[27] ? 28'(-sqr_r[SQRT_STEPS].dy) : sqr_r[SQRT_STEPS].dy;
    num_nxt.radius = sqr_r[SQRT_STEPS].radius;
    num_nxt.ex     = sqr_r[SQRT_STEPS].ex;
    num_nxt.hit    = sqr_r[SQRT_STEPS].hit;
    num_nxt.nz     = sqr_r[SQRT_STEPS].nz;
    num_nxt.sgnx   = sqr_r[SQRT_STEPS].dx[27];
    num_nxt.sgny   = sqr_r[SQRT_STEPS].dy[27];
    num_nxt.root   = sqr_r[SQRT_STEPS].res[30:0];
    num_nxt.numx   = {1'b0, adx[22:0], 22'b0} + 46'(sqr_r[SQRT_STEPS].res[30:1]);
    num_nxt.numy   = {1'b0, ady[22:0], 22'b0} + 46'(sqr_r[SQRT_STEPS].res[30:1]);

    nd0_nxt.radius = num_r.radius;
    nd0_nxt.ex     = num_r.ex;
    nd0_nxt.hit    = num_r.hit;
    nd0_nxt.nz     = num_r.nz;
    nd0_nxt.sgnx   = num_r.sgnx;
    nd0_nxt.sgny   = num_r.sgny;
    nd0_nxt.root   = num_r.root;
    nd0_nxt.ovfx   = {1'b0, num_r.numx} >= {num_r.root, 16'b0};
    nd0_nxt.ovfy   = {1'b0, num_r.numy} >= {num_r.root, 16'b0};
    nd0_nxt.remx   = {1'b0, num_r.numx};
    nd0_nxt.remy   = {1'b0, num_r.numy};
    nd0_nxt.qx     = '0;
    nd0_nxt.qy     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_v_r   <= 1'b0;
      nd_v_r[0] <= 1'b0;
    end else if (en) begin
      num_v_r   <= sq_vld_r[SQRT_STEPS];
      nd_v_r[0] <= num_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r   <= num_nxt;
      nd_r[0] <= nd0_nxt;
    end
  end

  // normal divider: one quotient bit per stage, both axes side by side
  for (genvar j = 0; j < NDIV_STEPS; j++) begin : g_ndiv
    logic [46:0] dsh;
    logic        gex, gey;
    ndiv_t       nxt;
    always_comb begin
      dsh    = {16'b0, nd_r[j].root} << (NDIV_STEPS - 1 - j);
      gex    = nd_r[j].remx >= dsh;
      gey    = nd_r[j].remy >= dsh;
      nxt    = nd_r[j];
      nxt.remx = gex ? nd_r[j].remx - dsh : nd_r[j].remx;
      nxt.remy = gey ? nd_r[j].remy - dsh : nd_r[j].remy;
      nxt.qx   = {nd_r[j].qx[14:0], gex};
      nxt.qy   = {nd_r[j].qy[14:0], gey};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nd_v_r[j+1] <= 1'b0;
      end else if (en) begin
        nd_v_r[j+1] <= nd_v_r[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        nd_r[j+1] <= nxt;
      end
    end
  end

  // saturate, sign, penetration depth
  logic [15:0] qsx, qsy;
  always_comb begin
    qsx = (nd_r[NDIV_STEPS].ovfx || nd_r[NDIV_STEPS].qx > ONE_Q14) ? ONE_Q14
                                                                    : nd_r[NDIV_STEPS].qx;
    qsy = (nd_r[NDIV_STEPS].ovfy || nd_r[NDIV_STEPS].qy > ONE_Q14) ? ONE_Q14
                                                                    : nd_r[NDIV_STEPS].qy;
    fin_nxt.ex  = nd_r[NDIV_STEPS].ex;
    fin_nxt.hit = nd_r[NDIV_STEPS].hit;
    fin_nxt.nz  = nd_r[NDIV_STEPS].nz;
    if (nd_r[NDIV_STEPS].hit && nd_r[NDIV_STEPS].nz) begin
      fin_nxt.nx = nd_r[NDIV_STEPS].sgnx ? -$signed(qsx) : $signed(qsx);
      fin_nxt.ny = nd_r[NDIV_STEPS].sgny ? -$signed(qsy) : $signed(qsy);
    end else begin
      fin_nxt.nx = '0;
      fin_nxt.ny = '0;
    end
    fin_nxt.pen = $signed({1'b0, nd_r[NDIV_STEPS].radius, 8'b0}) -
                  $signed({1'b0, nd_r[NDIV_STEPS].root});

    pp_nxt.ex  = fin_r.ex;
    pp_nxt.hit = fin_r.hit;
    pp_nxt.nz  = fin_r.nz;
    pp_nxt.nx  = fin_r.nx;
    pp_nxt.ny  = fin_r.ny;
    pp_nxt.ppx = $signed(fin_r.nx) * $signed(fin_r.pen);
    pp_nxt.ppy = $signed(fin_r.ny) * $signed(fin_r.pen);
  end

  // push rounding
  logic [47:0] pmx, pmy;
  logic [25:0] ptx, pty;
  always_comb begin
    pmx = pp_r.ppx[47] ? 48'(-pp_r.ppx) : 48'(pp_r.ppx);
    pmy = pp_r.ppy[47] ? 48'(-pp_r.ppy) : 48'(pp_r.ppy);
    ptx = 26'((pmx + 48'(1 << 21)) >> 22);
    pty = 26'((pmy + 48'(1 << 21)) >> 22);
    out_nx_nxt = pp_r.nx;
    out_ny_nxt = pp_r.ny;
    if (pp_r.hit && pp_r.nz && !pp_r.ex) begin
      out_px_nxt = pp_r.ppx[47] ? 24'(-ptx) : ptx[23:0];
      out_py_nxt = pp_r.ppy[47] ? 24'(-pty) : pty[23:0];
    end else begin
      out_px_nxt = '0;
      out_py_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
      pp_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= nd_v_r[NDIV_STEPS];
      pp_v_r  <= fin_v_r;
      out_v_r <= pp_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r     <= fin_nxt;
      pp_r      <= pp_nxt;
      out_hit_r <= pp_r.hit;
      out_ex_r  <= pp_r.ex;
      out_nx_r  <= out_nx_nxt;
      out_ny_r  <= out_ny_nxt;
      out_px_r  <= out_px_nxt;
      out_py_r  <= out_py_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {out_py_r, out_px_r, out_ny_r, out_nx_r};

  `CSC_ASSERT_NOW(a_miss_zero, clk, rst_n, out_v_r && !out_hit_r, out_tdata == '0,
    "miss beat carries nonzero normal or push")
  `CSC_ASSERT_NOW(a_exit_no_push, clk, rst_n, out_v_r && out_ex_r,
    out_px_r == '0 && out_py_r == '0, "exit wall produced a push")
  `CSC_ASSERT_NOW(a_zero_normal_no_push, clk, rst_n,
    out_v_r && out_nx_r == '0 && out_ny_r == '0,
    out_px_r == '0 && out_py_r == '0, "push without a normal")
  `CSC_ASSERT_NEXT(a_hit_reaches_out, clk, rst_n, en && pp_v_r && pp_r.hit,
    out_v_r && out_hit_r, "hit lost before the output register")

endmodule

`default_nettype wire

>>> tb/sv/circle_segment_collision_unit_test.sv
`timescale 1ns / 100ps
`default_nettype none

module circle_segment_collision_unit_test;

  typedef struct {
    logic signed [23:0] cx, cy;
    logic [22:0]        r;
    logic signed [23:0] ax, ay, bx, by;
    logic               ex;
  } wall_in_t;

  typedef struct {
    logic               hit;
    logic signed [15:0] nx, ny;
    logic signed [23:0] px, py;
  } contact_t;

  typedef struct {
    wall_in_t w;
    logic     known;
    contact_t c;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [167:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [79:0]  out_tdata;
  logic         out_tuser;

  contact_t contact_q[$];
  int       n_errors = 0;
  bit       feeding_done = 1'b0;
  row_t     rows[$];

  circle_segment_collision_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint rnd_shift(longint v, int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) <<< (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint div_near(longint num, longint den);
    longint m, q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    if (q > 16384) q = 16384;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint root_floor(logic [63:0] x);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic contact_t predict_contact(wall_in_t w);
    contact_t c;
    longint apx, apy, abx, aby, dot, len2, u, dx, dy, d2, root, nx, ny, pen;
    c = '{hit: 0, nx: 0, ny: 0, px: 0, py: 0};
    apx = longint'(w.cx) - longint'(w.ax);
    apy = longint'(w.cy) - longint'(w.ay);
    abx = longint'(w.bx) - longint'(w.ax);
    aby = longint'(w.by) - longint'(w.ay);
    dot = apx * abx + apy * aby;
    len2 = abx * abx + aby * aby;
    if (len2 == 0 || dot < 0 || dot > len2) return c;
    // dot <= len2 < 2^51, so shifting by 24 fits in 75 bits: use 128-bit math
    u = longint'(({64'd0, 64'(dot)} << 24) / {64'd0, 64'(len2)});
    dx = apx - rnd_shift(u * abx, 24);
    dy = apy - rnd_shift(u * aby, 24);
    d2 = dx * dx + dy * dy;
    if (d2 >= longint'(w.r) * longint'(w.r)) return c;
    c.hit = 1'b1;
    if (d2 != 0) begin
      root = root_floor(64'(d2) << 16);
      nx = div_near(dx <<< 22, root);
      ny = div_near(dy <<< 22, root);
      c.nx = 16'(nx);
      c.ny = 16'(ny);
      if (!w.ex) begin
        pen = (longint'(w.r) <<< 8) - root;
        c.px = 24'(rnd_shift(nx * pen, 22));
        c.py = 24'(rnd_shift(ny * pen, 22));
      end
    end
    return c;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    n_errors++;
  endtask

  function automatic logic signed [23:0] rnd_coord(int span);
    case ($urandom_range(0, 9))
      0: return 24'sh800000;
      1: return 24'sh7fffff;
      2: return 24'($urandom);
      default: return 24'($signed($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  function automatic wall_in_t rnd_wall();
    wall_in_t w;
    int span, sel;
    span = ($urandom_range(0, 3) == 0) ? 8388607 : $urandom_range(16, 200000);
    sel = $urandom_range(0, 9);
    w.ax = rnd_coord(span);
    w.ay = rnd_coord(span);
    w.bx = rnd_coord(span);
    w.by = rnd_coord(span);
    w.ex = 1'($urandom_range(0, 1));
    if (sel < 7) begin
      // center near a point on the segment, radius on the order of the offset
      longint t, px, py, off;
      t = $urandom_range(0, 1024);
      px = longint'(w.ax) + ((longint'(w.bx) - longint'(w.ax)) * t) / 1024;
      py = longint'(w.ay) + ((longint'(w.by) - longint'(w.ay)) * t) / 1024;
      off = $urandom_range(0, span / 4 + 1);
      px = px + longint'($urandom_range(0, 32'(2 * off))) - off;
      py = py + longint'($urandom_range(0, 32'(2 * off))) - off;
      if (px > 8388607) px = 8388607;
      if (px < -8388608) px = -8388608;
      if (py > 8388607) py = 8388607;
      if (py < -8388608) py = -8388608;
      w.cx = 24'(px);
      w.cy = 24'(py);
      w.r = 23'($urandom_range(0, 32'(2 * off + 2)));
    end else begin
      w.cx = rnd_coord(span);
      w.cy = rnd_coord(span);
      w.r = ($urandom_range(0, 7) == 0) ? 23'h7fffff : 23'($urandom);
    end
    return w;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 2) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic add_row(wall_in_t w, logic known, contact_t c);
    row_t rw;
    rw.w = w;
    rw.known = known;
    rw.c = c;
    rows.push_back(rw);
  endtask

  initial begin
    contact_t none;
    wall_in_t w;
    int gap;
    none = '{hit: 0, nx: 0, ny: 0, px: 0, py: 0};
    // zero-length segment
    add_row('{100, 100, 500, 0, 0, 0, 0, 0}, 1, none);
    // projection before start and past end
    add_row('{-2560, 0, 5000, 0, 0, 2560, 0, 0}, 1, none);
    add_row('{5120, 0, 5000, 0, 0, 2560, 0, 0}, 1, none);
    // center on the segment
    add_row('{1280, 0, 256, 0, 0, 2560, 0, 0}, 1, '{1, 0, 0, 0, 0});
    add_row('{1280, 0, 256, 0, 0, 2560, 0, 1}, 1, '{1, 0, 0, 0, 0});
    // zero radius on the segment
    add_row('{1280, 0, 0, 0, 0, 2560, 0, 0}, 1, none);
    // plain hits above and below, normal exactly vertical, and a miss at exactly the radius
    add_row('{1280, 256, 512, 0, 0, 2560, 0, 0}, 1, '{1, 0, 16384, 0, 256});
    add_row('{1280, -256, 512, 0, 0, 2560, 0, 1}, 1, '{1, 0, -16384, 0, 0});
    add_row('{1280, 256, 256, 0, 0, 2560, 0, 0}, 1, none);
    // center left of a vertical wall, normal points to negative x
    add_row('{-256, 1280, 512, 0, 0, 0, 2560, 0}, 1, '{1, -16384, 0, -256, 0});
    // extremes, then two small walls
    add_row('{24'sh7fffff, 24'sh7fffff, 23'h7fffff, 24'sh800000, 24'sh800000,
              24'sh7fffff, 24'sh7fffff, 1}, 0, none);
    add_row('{24'sh800000, 24'sh7fffff, 23'h7fffff, 24'sh800000, 24'sh800000,
              24'sh7fffff, 24'sh7fffff, 0}, 0, none);
    add_row('{0, 0, 23'h7fffff, 24'sh800000, 24'sh7fffff,
              24'sh7fffff, 24'sh800000, 0}, 0, none);
    add_row('{24'sh7fffff, 24'sh800000, 23'h7fffff, 24'sh800000, 24'sh800000,
              24'sh7fffff, 24'sh7fffff, 0}, 0, none);
    add_row('{-1, -1, 23'h7fffff, -1, -2, -1, 24'sh7fffff, 0}, 0, none);
    add_row('{3, 7, 9, 0, 0, 1, 1, 0}, 0, none);
    add_row('{1000, 1000, 300, 0, 0, 1, 1, 0}, 0, none);
    for (int i = 0; i < 1750; i++) add_row(rnd_wall(), 0, none);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    gap = gap_len();
    foreach (rows[i]) begin
      repeat (gap) @(posedge clk);
      w = rows[i].w;
      in_tvalid <= 1'b1;
      in_tdata <= {1'b0, w.by, w.bx, w.ay, w.ax, w.r, w.cy, w.cx};
      in_tuser <= w.ex;
      contact_q.push_back(rows[i].known ? rows[i].c : predict_contact(w));
      do @(posedge clk); while (!in_tready);
      gap = gap_len();
      if (gap != 0 || i == rows.size() - 1) in_tvalid <= 1'b0;
    end
    in_tvalid <= 1'b0;
    feeding_done = 1'b1;
  end

  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = gap_len();
      out_tready <= (stall == 0);
      repeat ((stall == 0) ? 1 : stall) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (contact_q.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        contact_t c;
        c = contact_q.pop_front();
        if (out_tuser !== c.hit) report_mismatch("hit", out_tuser, c.hit);
        if (out_tdata[15:0] !== c.nx)
          report_mismatch("normal_x", $signed(out_tdata[15:0]), c.nx);
        if (out_tdata[31:16] !== c.ny)
          report_mismatch("normal_y", $signed(out_tdata[31:16]), c.ny);
        if (out_tdata[55:32] !== c.px)
          report_mismatch("push_x", $signed(out_tdata[55:32]), c.px);
        if (out_tdata[79:56] !== c.py)
          report_mismatch("push_y", $signed(out_tdata[79:56]), c.py);
      end
    end
  end

  initial begin
    wait (feeding_done);
    while (contact_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_errors == 0 && contact_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
